### hw/rtl/dcpd_pkg.sv
// ----------------------------------------------------------------------------
// dcpd_pkg
// Types, constants and register codes of the double coil pulse driver.
// ----------------------------------------------------------------------------
`default_nettype none

package dcpd_pkg;

  localparam int unsigned TicksPerUnit = 10;
  localparam int unsigned TimeW        = 8;
  localparam int unsigned TimeMax      = (1 << TimeW) - 1;
  localparam int unsigned TimerW       = $clog2(TimeMax * TicksPerUnit + 1);
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = TimeW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStaticMode   = 3'd0,
    CfgInvert       = 3'd1,
    CfgSkipCheck    = 3'd2,
    CfgAutoOffOnly  = 3'd3,
    CfgPulseTime    = 3'd4,
    CfgPauseTime    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             static_mode;
    logic             invert_outputs;
    logic             skip_position_check;
    logic             auto_off_only;
    logic [TimeW-1:0] pulse_time;
    logic [TimeW-1:0] pause_time;
  } cfg_t;

  typedef struct packed {
    logic              pulse_active;
    logic              target_coil;
    logic              actual_coil;
    logic              target_on;
    logic              request_pending;
    logic [TimerW-1:0] timer_remaining;
    logic [2:0]        drive_levels;
    logic [1:0]        position_record;
  } state_t;

  typedef struct packed {
    logic       func;
    logic       coil_select;
    logic       coil_on;
  } item_t;

  typedef struct packed {
    logic       coil_one_drive;
    logic       coil_two_drive;
    logic       target_indicator;
    logic [1:0] saved_position;
  } res_t;

  localparam state_t StateReset = '{
    pulse_active:    1'b0,
    target_coil:     1'b0,
    actual_coil:     1'b1,
    target_on:       1'b0,
    request_pending: 1'b1,
    timer_remaining: '0,
    drive_levels:    3'b000,
    position_record: 2'b00
  };

endpackage

`default_nettype wire

### hw/rtl/dcpd_if.sv
// ----------------------------------------------------------------------------
// dcpd_cmd_if / dcpd_res_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcpd_cmd_if;
  logic valid;
  logic ready;
  logic func;
  logic coil_select;
  logic coil_on;

  modport source (output valid, output func, output coil_select, output coil_on,
                  input ready);
  modport sink   (input valid, input func, input coil_select, input coil_on,
                  output ready);
endinterface

interface dcpd_res_if;
  logic       valid;
  logic       ready;
  logic       coil_one_drive;
  logic       coil_two_drive;
  logic       target_indicator;
  logic [1:0] saved_position;

  modport source (output valid, output coil_one_drive, output coil_two_drive,
                  output target_indicator, output saved_position, input ready);
  modport sink   (input valid, input coil_one_drive, input coil_two_drive,
                  input target_indicator, input saved_position, output ready);
endinterface

`default_nettype wire

### hw/rtl/dcpd_step.sv
// ----------------------------------------------------------------------------
// dcpd_step
// Next state of the driver for one command or one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpd_step import dcpd_pkg::*; (
  input  cfg_t   cfg_i,
  input  state_t st_i,
  input  item_t  item_i,
  output state_t st_o
);

  logic [TimerW-1:0] pulse_ticks;
  logic [TimerW-1:0] pause_ticks;

  assign pulse_ticks = TimerW'(cfg_i.pulse_time) * TimerW'(TicksPerUnit);
  assign pause_ticks = TimerW'(cfg_i.pause_time) * TimerW'(TicksPerUnit);

  always_comb begin
    logic lvl;
    st_o = st_i;
    lvl  = item_i.coil_on ^ cfg_i.invert_outputs;
    if (!item_i.func) begin
      st_o.target_coil     = item_i.coil_select;
      st_o.target_on       = item_i.coil_on;
      st_o.request_pending = 1'b1;
      if (cfg_i.static_mode) begin
        if (item_i.coil_select) begin
          st_o.drive_levels[1] = lvl;
        end else begin
          st_o.drive_levels[0] = lvl;
        end
        st_o.position_record = st_o.drive_levels[1:0]
                               ^ {2{cfg_i.invert_outputs}};
      end
      st_o.drive_levels[2] = item_i.coil_select ^ cfg_i.invert_outputs;
    end else if (!cfg_i.static_mode) begin
      if (st_o.timer_remaining != '0) begin
        st_o.timer_remaining = st_o.timer_remaining - TimerW'(1);
      end
      if (!st_o.pulse_active && st_o.timer_remaining == '0 && st_o.request_pending) begin
        if ((st_o.actual_coil != st_o.target_coil || cfg_i.skip_position_check)
            && st_o.target_on) begin
          st_o.drive_levels[1:0] = st_o.target_coil ? 2'b10 : 2'b01;
          st_o.pulse_active      = 1'b1;
          if (cfg_i.pulse_time != '0) begin
            st_o.timer_remaining = pulse_ticks;
          end
          st_o.actual_coil     = st_o.target_coil;
          st_o.position_record = {1'b0, st_o.target_coil};
        end
        st_o.request_pending = 1'b0;
      end
      if (st_o.pulse_active) begin
        if (!cfg_i.auto_off_only && st_o.request_pending && !st_o.target_on) begin
          st_o.pulse_active    = 1'b0;
          st_o.timer_remaining = '0;
          st_o.request_pending = 1'b0;
        end
        if (cfg_i.pulse_time != '0 && st_o.timer_remaining == '0) begin
          st_o.pulse_active = 1'b0;
        end
        if (!st_o.pulse_active) begin
          st_o.drive_levels[1:0] = 2'b00;
          if (cfg_i.pause_time != '0) begin
            st_o.timer_remaining = pause_ticks;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/double_coil_pulse_driver_core.sv
// ----------------------------------------------------------------------------
// double_coil_pulse_driver_core
// Two-coil point motor driver: commands and millisecond ticks in, one result
// transaction with the output levels and the saved position per item out.
//
//   channel  dir  fields
//   cmd_i    in   func, coil_select, coil_on
//   res_o    out  coil_one_drive, coil_two_drive, target_indicator,
//                 saved_position
//   cfg      in   cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// one item per cycle while cmd_i.ready is high; each result is registered on acceptance
// the state update is a single combinational pass from the state registers
// a two-entry output stage (result register plus skid) keeps input flowing
// while a result waits; cmd_i.ready drops only when both entries are full
// rst_ni clears configuration, sequencer state and the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module double_coil_pulse_driver_core import dcpd_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  dcpd_cmd_if.sink            cmd_i,
  dcpd_res_if.source          res_o
);

  cfg_t   cfg_q;
  state_t st_q, st_d;
  item_t  item;
  res_t   res_d, out_q, skid_q;
  logic   out_valid_q, skid_valid_q;
  logic   accept, take;

  assign item   = '{func: cmd_i.func, coil_select: cmd_i.coil_select,
                    coil_on: cmd_i.coil_on};
  assign cmd_i.ready = !skid_valid_q;
  assign accept = cmd_i.valid && cmd_i.ready;
  assign take   = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgStaticMode:  cfg_q.static_mode         <= cfg_data_i[0];
        CfgInvert:      cfg_q.invert_outputs      <= cfg_data_i[0];
        CfgSkipCheck:   cfg_q.skip_position_check <= cfg_data_i[0];
        CfgAutoOffOnly: cfg_q.auto_off_only       <= cfg_data_i[0];
        CfgPulseTime:   cfg_q.pulse_time          <= cfg_data_i[TimeW-1:0];
        CfgPauseTime:   cfg_q.pause_time          <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  dcpd_step u_step (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .item_i (item),
    .st_o   (st_d)
  );

  assign res_d = '{coil_one_drive:   st_d.drive_levels[0],
                   coil_two_drive:   st_d.drive_levels[1],
                   target_indicator: st_d.drive_levels[2],
                   saved_position:   st_d.position_record};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.coil_one_drive   = out_q.coil_one_drive;
  assign res_o.coil_two_drive   = out_q.coil_two_drive;
  assign res_o.target_indicator = out_q.target_indicator;
  assign res_o.saved_position   = out_q.saved_position;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without result entry");

  // a stalled, full output stage loses nothing
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !res_o.ready) |=> (skid_valid_q && out_valid_q))
    else $error("output stage dropped a transaction");

  // timer never exceeds the longest pulse or pause
  a_timer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.timer_remaining <= TimerW'(TimeMax * TicksPerUnit))
    else $error("timer out of range");

  // a stalled result stays valid and unchanged
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

### test/tb_double_coil_pulse_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_coil_pulse_driver_core
// Self-checking bench for the two-coil pulse driver. A behavioral copy of the
// sequencer predicts the output levels of every command and tick transaction.
// Results are checked in order against those predictions. Register settings
// are swept while the block is idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_double_coil_pulse_driver_core;
  import dcpd_pkg::*;

  localparam logic FuncCommand = 1'b0;
  localparam logic FuncTick    = 1'b1;
  localparam int   MaxPrinted  = 30;

  localparam item_t TickItem = '{func: FuncTick, coil_select: 1'b0, coil_on: 1'b0};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dcpd_cmd_if cmd_ch ();
  dcpd_res_if res_ch ();

  double_coil_pulse_driver_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch)
  );

  cfg_t   drv_cfg;
  state_t coil_st;
  res_t   levels_q[$];

  bit idle_en       = 1'b1;
  int src_gap_pct   = 20;
  int snk_stall_pct = 20;
  int stall_left    = 0;

  int n_errors   = 0;
  int n_items    = 0;
  int n_ticks    = 0;
  int n_results  = 0;
  int n_settings = 0;

  always #4 clk_i = ~clk_i;

  // predicted levels after one command or tick
  function automatic res_t step_coil_driver(input item_t it);
    res_t r;
    logic lvl;
    if (it.func == FuncCommand) begin
      coil_st.target_coil     = it.coil_select;
      coil_st.target_on       = it.coil_on;
      coil_st.request_pending = 1'b1;
      if (drv_cfg.static_mode) begin
        lvl = it.coil_on ^ drv_cfg.invert_outputs;
        if (it.coil_select) coil_st.drive_levels[1] = lvl;
        else coil_st.drive_levels[0] = lvl;
        coil_st.position_record = coil_st.drive_levels[1:0] ^ {2{drv_cfg.invert_outputs}};
      end
      coil_st.drive_levels[2] = coil_st.target_coil ^ drv_cfg.invert_outputs;
    end else if (!drv_cfg.static_mode) begin
      if (coil_st.timer_remaining != '0) coil_st.timer_remaining--;
      if (!coil_st.pulse_active && coil_st.timer_remaining == '0 &&
          coil_st.request_pending) begin
        if ((coil_st.actual_coil != coil_st.target_coil || drv_cfg.skip_position_check) &&
            coil_st.target_on) begin
          coil_st.drive_levels[1:0] = coil_st.target_coil ? 2'b10 : 2'b01;
          coil_st.pulse_active      = 1'b1;
          if (drv_cfg.pulse_time != '0)
            coil_st.timer_remaining = TimerW'(drv_cfg.pulse_time * TicksPerUnit);
          coil_st.actual_coil     = coil_st.target_coil;
          coil_st.position_record = {1'b0, coil_st.target_coil};
        end
        coil_st.request_pending = 1'b0;
      end
      if (coil_st.pulse_active) begin
        if (!drv_cfg.auto_off_only && coil_st.request_pending && !coil_st.target_on) begin
          coil_st.pulse_active    = 1'b0;
          coil_st.timer_remaining = '0;
          coil_st.request_pending = 1'b0;
        end
        if (drv_cfg.pulse_time != '0 && coil_st.timer_remaining == '0)
          coil_st.pulse_active = 1'b0;
        if (!coil_st.pulse_active) begin
          coil_st.drive_levels[1:0] = 2'b00;
          if (drv_cfg.pause_time != '0)
            coil_st.timer_remaining = TimerW'(drv_cfg.pause_time * TicksPerUnit);
        end
      end
    end
    r.coil_one_drive   = coil_st.drive_levels[0];
    r.coil_two_drive   = coil_st.drive_levels[1];
    r.target_indicator = coil_st.drive_levels[2];
    r.saved_position   = coil_st.position_record;
    return r;
  endfunction

  function automatic item_t mk_cmd(input logic sel, input logic on);
    item_t it;
    it.func        = FuncCommand;
    it.coil_select = sel;
    it.coil_on     = on;
    return it;
  endfunction

  function automatic item_t rand_item(input int tick_pct);
    item_t it;
    it.func        = ($urandom_range(0, 99) < tick_pct) ? FuncTick : FuncCommand;
    it.coil_select = 1'($urandom_range(0, 1));
    it.coil_on     = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= MaxPrinted)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_item(input item_t it);
    if (idle_en && $urandom_range(0, 99) < src_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= it.func;
    cmd_ch.coil_select <= it.coil_select;
    cmd_ch.coil_on     <= it.coil_on;
    do @(posedge clk_i); while (!cmd_ch.ready);
    levels_q.push_back(step_coil_driver(it));
    n_items++;
    if (it.func == FuncTick) n_ticks++;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    cmd_ch.valid <= 1'b0;
    while (levels_q.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (levels_q.size() != 0) begin
      flag_mismatch("results missing", 0, levels_q.size());
      levels_q.delete();
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    drain_results();
    put_reg(CfgStaticMode,  CfgDataW'(c.static_mode));
    put_reg(CfgInvert,      CfgDataW'(c.invert_outputs));
    put_reg(CfgSkipCheck,   CfgDataW'(c.skip_position_check));
    put_reg(CfgAutoOffOnly, CfgDataW'(c.auto_off_only));
    put_reg(CfgPulseTime,   c.pulse_time);
    put_reg(CfgPauseTime,   c.pause_time);
    cfg_we_i <= 1'b0;
    drv_cfg = c;
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int tick_pct, input bit on_only);
    item_t it;
    for (int k = 0; k < count; k++) begin
      it = rand_item(tick_pct);
      if (on_only) it.coil_on = 1'b1;
      send_item(it);
    end
  endtask

  // held pulse, early off, already in position, stray off
  task automatic test_pulse_basics();
    send_item(TickItem);
    send_item(mk_cmd(1'b0, 1'b1));
    send_item(TickItem);
    send_item(TickItem);
    send_item(mk_cmd(1'b0, 1'b0));
    send_item(TickItem);
    send_item(mk_cmd(1'b0, 1'b1));
    send_item(TickItem);
    send_item(mk_cmd(1'b1, 1'b0));
    send_item(TickItem);
  endtask

  // endless pulse under auto-off, static freeze and resume
  task automatic test_special_cases();
    cfg_t c;
    c = '0;
    c.auto_off_only = 1'b1;
    load_settings(c);
    send_item(mk_cmd(1'b1, 1'b1));
    send_item(TickItem);
    send_item(mk_cmd(1'b1, 1'b0));
    send_item(TickItem);
    c.static_mode         = 1'b1;
    c.invert_outputs      = 1'b1;
    c.skip_position_check = 1'b1;
    c.pulse_time          = 8'd255;
    c.pause_time          = 8'd255;
    load_settings(c);
    send_item(mk_cmd(1'b0, 1'b1));
    send_item(mk_cmd(1'b1, 1'b1));
    send_item(TickItem);
    send_item(mk_cmd(1'b0, 1'b0));
    c = '0;
    load_settings(c);
    send_item(TickItem);
    send_item(TickItem);
  endtask

  task automatic test_random_settings();
    cfg_t c;
    for (int p = 0; p < 10; p++) begin
      c = '0;
      case (p)
        0: c.pulse_time = 8'd1;
        1: begin
          c.pulse_time          = 8'd1;
          c.pause_time          = 8'd1;
          c.skip_position_check = 1'b1;
        end
        2: begin
          c.pulse_time    = 8'd2;
          c.pause_time    = 8'd1;
          c.auto_off_only = 1'b1;
        end
        3: c.pause_time = 8'd1;
        4: begin
          c.pulse_time          = 8'd255;
          c.pause_time          = 8'd255;
          c.skip_position_check = 1'b1;
        end
        5: c.static_mode = 1'b1;
        6: begin
          c.static_mode    = 1'b1;
          c.invert_outputs = 1'b1;
        end
        default: begin
          c.static_mode         = ($urandom_range(0, 5) == 0);
          c.invert_outputs      = 1'($urandom_range(0, 1));
          c.skip_position_check = 1'($urandom_range(0, 1));
          c.auto_off_only       = 1'($urandom_range(0, 1));
          c.pulse_time          = TimeW'($urandom_range(0, 3));
          c.pause_time          = TimeW'($urandom_range(0, 3));
        end
      endcase
      src_gap_pct   = $urandom_range(0, 2) * 15;
      snk_stall_pct = $urandom_range(0, 2) * 15;
      load_settings(c);
      if (p == 4) begin
        run_random(60, 85, 1'b1);
        // cut the long pulse short so later settings start from a quiet timer
        c = '0;
        c.pulse_time = 8'd1;
        load_settings(c);
        send_item(mk_cmd(1'b0, 1'b0));
        send_item(TickItem);
      end else begin
        run_random(125, c.static_mode ? 40 : 80, 1'b0);
      end
    end
  endtask

  task automatic test_no_idle_tail();
    cfg_t c;
    c = '0;
    c.invert_outputs      = 1'($urandom_range(0, 1));
    c.skip_position_check = 1'($urandom_range(0, 1));
    c.pulse_time          = 8'd1;
    c.pause_time          = 8'd1;
    load_settings(c);
    idle_en = 1'b0;
    run_random(150, 80, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      res_ch.ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < snk_stall_pct) begin
      stall_left    <= $urandom_range(0, 5);
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready  <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (levels_q.size() == 0) begin
        flag_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = levels_q.pop_front();
        if (res_ch.coil_one_drive !== want.coil_one_drive)
          flag_mismatch("coil_one_drive", res_ch.coil_one_drive, want.coil_one_drive);
        if (res_ch.coil_two_drive !== want.coil_two_drive)
          flag_mismatch("coil_two_drive", res_ch.coil_two_drive, want.coil_two_drive);
        if (res_ch.target_indicator !== want.target_indicator)
          flag_mismatch("target_indicator", res_ch.target_indicator, want.target_indicator);
        if (res_ch.saved_position !== want.saved_position)
          flag_mismatch("saved_position", res_ch.saved_position, want.saved_position);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[double_coil_pulse_driver_core] ERROR");
    $finish;
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CfgStaticMode;
    cfg_data_i         <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FuncTick;
    cmd_ch.coil_select <= 1'b0;
    cmd_ch.coil_on     <= 1'b0;
    coil_st = StateReset;
    drv_cfg = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_pulse_basics();
    test_special_cases();
    test_random_settings();
    test_no_idle_tail();
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("covered %0d transactions (%0d ticks, %0d commands) over %0d register settings",
             n_items, n_ticks, n_items - n_ticks, n_settings);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("[double_coil_pulse_driver_core] OK");
    end else begin
      $display("[double_coil_pulse_driver_core] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dcpd_pkg.sv
hw/rtl/dcpd_if.sv
hw/rtl/dcpd_step.sv
hw/rtl/double_coil_pulse_driver_core.sv
test/tb_double_coil_pulse_driver_core.sv
